// ===== src/mia_pkg.sv =====
// ----------------------------------------------------------------------------
// mia_pkg
// Operation codes and the result bundle shared by the MIPS32 integer ALU.
// ----------------------------------------------------------------------------
package mia_pkg;

    localparam int unsigned ImmBits   = 16;
    localparam logic [4:0]  ShamtMask = 5'h1f;

    typedef enum logic [4:0] {
        MODE_LUI   = 5'd0,
        MODE_OR    = 5'd1,
        MODE_ADDIU = 5'd2,
        MODE_ADDU  = 5'd3,
        MODE_XOR   = 5'd4,
        MODE_SLTIU = 5'd5,
        MODE_SLTU  = 5'd6,
        MODE_SLTI  = 5'd7,
        MODE_SRA   = 5'd8,
        MODE_ANDI  = 5'd9,
        MODE_SRLV  = 5'd10,
        MODE_SLLV  = 5'd11,
        MODE_XORI  = 5'd12,
        MODE_NOR   = 5'd13,
        MODE_AND   = 5'd14,
        MODE_SLT   = 5'd15,
        MODE_SUBU  = 5'd16,
        MODE_MOVN  = 5'd17,
        MODE_MOVZ  = 5'd18,
        MODE_ORI   = 5'd19,
        MODE_MULTU = 5'd20,
        MODE_MULT  = 5'd21,
        MODE_SRL   = 5'd22,
        MODE_SLL   = 5'd23,
        MODE_SRAV  = 5'd24
    } mode_t;

    typedef struct packed {
        logic [31:0] dest_value;
        logic        dest_write;
        logic [31:0] hi_value;
        logic [31:0] lo_value;
        logic        hilo_write;
    } alu_result_t;

endpackage

// ===== src/mips32_integer_alu.sv =====
// ----------------------------------------------------------------------------
// mips32_integer_alu
// MIPS32 integer execute stage with stream input and output.
// ----------------------------------------------------------------------------
// Each item is one instruction: an operation code on s_tuser and two operands
// on s_tdata. The block takes one item per cycle. An input register feeds the
// ALU and 33x33 multiplier, whose outputs land in a result register that
// drives m_tvalid, m_tdata and m_tuser. While a finished result waits for
// m_tready the input register can still take one more item; with both
// registers full s_tready drops until m_tready returns. Operation codes 25
// to 31 return a result with every field zero.
module mips32_integer_alu
    import mia_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // operand_a[31:0], operand_b[63:32]
    input  logic [7:0]   s_tuser,   // mode[4:0], zero[7:5]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // dest_value[31:0], hi_value[63:32], lo_value[95:64]
    output logic [7:0]   m_tuser    // dest_write[0], hilo_write[1], zero[7:2]
);

    logic        in_valid_reg;
    logic [4:0]  mode_reg;
    logic [31:0] operand_a_reg;
    logic [31:0] operand_b_reg;

    logic        out_valid_reg;
    alu_result_t result_reg;
    alu_result_t result_next;

    logic        out_advance;
    logic        in_advance;

    assign out_advance = !out_valid_reg || m_tready;
    assign in_advance  = !in_valid_reg || out_advance;
    assign s_tready    = in_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_advance)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && in_advance)
        begin
            mode_reg      <= s_tuser[4:0];
            operand_a_reg <= s_tdata[31:0];
            operand_b_reg <= s_tdata[63:32];
        end
        if (in_valid_reg && out_advance)
        begin
            result_reg <= result_next;
        end
    end

    mia_exec u_exec (
        .mode      (mode_t'(mode_reg)),
        .operand_a (operand_a_reg),
        .operand_b (operand_b_reg),
        .result    (result_next)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {result_reg.lo_value, result_reg.hi_value, result_reg.dest_value};
    assign m_tuser  = {6'd0, result_reg.hilo_write, result_reg.dest_write};

    // a result never writes both the general register and HI/LO
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("dest_write and hilo_write both set");

    // HI/LO stay zero unless a multiply writes them
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[1]) |-> (m_tdata[95:32] == 64'd0))
        else $error("hi/lo nonzero without hilo_write");

    // destination value stays zero when not written
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[31:0] == 32'd0))
        else $error("dest_value nonzero without dest_write");

    // an empty input register always takes an item
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input stage empty but not ready");

    // a stalled result holds while a queued item waits behind it
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready && in_valid_reg) |=> (in_valid_reg && out_valid_reg))
        else $error("item lost under output stall");

endmodule

// ===== src/mia_exec.sv =====
// ----------------------------------------------------------------------------
// mia_exec
// Combinational execute logic: one operation on two 32-bit operands.
// ----------------------------------------------------------------------------
module mia_exec
    import mia_pkg::*;
(
    input  mode_t       mode,
    input  logic [31:0] operand_a,
    input  logic [31:0] operand_b,
    output alu_result_t result
);

    logic [31:0]        imm_sext;
    logic [31:0]        imm_zext;
    logic [4:0]         shamt;
    logic               mul_signed;
    logic signed [65:0] product;

    assign imm_sext   = {{(32 - ImmBits){operand_b[ImmBits-1]}}, operand_b[ImmBits-1:0]};
    assign imm_zext   = {{(32 - ImmBits){1'b0}}, operand_b[ImmBits-1:0]};
    assign shamt      = operand_b[4:0] & ShamtMask;
    assign mul_signed = (mode == MODE_MULT);

    // one 33x33 signed multiplier serves both mult and multu
    assign product = $signed({mul_signed & operand_a[31], operand_a})
                   * $signed({mul_signed & operand_b[31], operand_b});

    always_comb
    begin
        result            = '0;
        result.dest_write = 1'b1;
        case (mode)
            MODE_LUI:   result.dest_value = {operand_b[ImmBits-1:0], {ImmBits{1'b0}}};
            MODE_OR:    result.dest_value = operand_a | operand_b;
            MODE_ADDIU: result.dest_value = operand_a + imm_sext;
            MODE_ADDU:  result.dest_value = operand_a + operand_b;
            MODE_XOR:   result.dest_value = operand_a ^ operand_b;
            MODE_SLTIU: result.dest_value = {31'd0, operand_a < imm_sext};
            MODE_SLTU:  result.dest_value = {31'd0, operand_a < operand_b};
            MODE_SLTI:  result.dest_value = {31'd0, $signed(operand_a) < $signed(imm_sext)};
            MODE_SRA:   result.dest_value = 32'($signed(operand_a) >>> shamt);
            MODE_ANDI:  result.dest_value = operand_a & imm_zext;
            MODE_SRLV:  result.dest_value = operand_a >> shamt;
            MODE_SLLV:  result.dest_value = operand_a << shamt;
            MODE_XORI:  result.dest_value = operand_a ^ imm_zext;
            MODE_NOR:   result.dest_value = ~(operand_a | operand_b);
            MODE_AND:   result.dest_value = operand_a & operand_b;
            MODE_SLT:   result.dest_value = {31'd0, $signed(operand_a) < $signed(operand_b)};
            MODE_SUBU:  result.dest_value = operand_a - operand_b;
            MODE_MOVN:
            begin
                result.dest_write = (operand_b != 32'd0);
                result.dest_value = result.dest_write ? operand_a : 32'd0;
            end
            MODE_MOVZ:
            begin
                result.dest_write = (operand_b == 32'd0);
                result.dest_value = result.dest_write ? operand_a : 32'd0;
            end
            MODE_ORI:   result.dest_value = operand_a | imm_zext;
            MODE_MULTU, MODE_MULT:
            begin
                result.dest_write = 1'b0;
                result.hi_value   = product[63:32];
                result.lo_value   = product[31:0];
                result.hilo_write = 1'b1;
            end
            MODE_SRL:   result.dest_value = operand_a >> shamt;
            MODE_SLL:   result.dest_value = operand_a << shamt;
            MODE_SRAV:  result.dest_value = 32'($signed(operand_a) >>> shamt);
            // undefined codes write nothing
            default:    result.dest_write = 1'b0;
        endcase
    end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stream-level test of the MIPS32 integer ALU. A short table of directed
// instructions covers every operation, the operand extremes, failed
// conditional moves and an undefined operation code. Random instructions
// with corner-heavy operands follow. Each accepted result is compared field
// by field against an in-order queue of expected results, typed in or from
// a local model, while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
    import mia_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [4:0]  MODE_UNDEF_LO = 5'd25;
    localparam logic [4:0]  MODE_UNDEF_HI = 5'd31;
    localparam int unsigned NumRows       = 28;
    localparam int unsigned NumRandom     = 600;
    localparam int unsigned HoldAt        = 150;
    localparam int unsigned HoldCycles    = 250;
    localparam int unsigned DrainCycles   = 10;

    typedef struct {
        logic [4:0]  mode;
        logic [31:0] opa;
        logic [31:0] opb;
        bit          typed;
        alu_result_t want;
    } alu_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [63:0]  s_tdata;    // operand_a[31:0], operand_b[63:32]
    logic [7:0]   s_tuser;    // mode[4:0], zero[7:5]
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;    // dest_value[31:0], hi_value[63:32], lo_value[95:64]
    logic [7:0]   m_tuser;    // dest_write[0], hilo_write[1], zero[7:2]

    alu_result_t  results_q[$];
    int unsigned  sent_count;
    int unsigned  err_count;

    // Expected results are typed in where they are plain; the rest go to the model.
    alu_row_t dir_rows [NumRows] = '{
        '{MODE_LUI,      32'h0000_0000, 32'hdead_ffff, 1'b1,
          '{32'hffff_0000, 1'b1, 32'h0, 32'h0, 1'b0}},
        '{MODE_OR,       32'hffff_ffff, 32'h0000_0000, 1'b1,
          '{32'hffff_ffff, 1'b1, 32'h0, 32'h0, 1'b0}},
        '{MODE_ADDIU,    32'h0000_0000, 32'h0000_8000, 1'b1,
          '{32'hffff_8000, 1'b1, 32'h0, 32'h0, 1'b0}},
        '{MODE_ADDU,     32'hffff_ffff, 32'h0000_0001, 1'b1,
          '{32'h0000_0000, 1'b1, 32'h0, 32'h0, 1'b0}},
        '{MODE_XOR,      32'hffff_ffff, 32'hffff_ffff, 1'b1,
          '{32'h0000_0000, 1'b1, 32'h0, 32'h0, 1'b0}},
        '{MODE_SLTIU,    32'hffff_fffe, 32'h0000_ffff, 1'b1,
          '{32'h0000_0001, 1'b1, 32'h0, 32'h0, 1'b0}},
        '{MODE_SLTU,     32'h0000_0000, 32'hffff_ffff, 1'b1,
          '{32'h0000_0001, 1'b1, 32'h0, 32'h0, 1'b0}},
        '{MODE_SLTI,     32'h8000_0000, 32'h0000_0001, 1'b1,
          '{32'h0000_0001, 1'b1, 32'h0, 32'h0, 1'b0}},
        '{MODE_SRA,      32'h8000_0000, 32'hffff_ffff, 1'b1,
          '{32'hffff_ffff, 1'b1, 32'h0, 32'h0, 1'b0}},
        '{MODE_ANDI,     32'hffff_ffff, 32'hffff_ffff, 1'b1,
          '{32'h0000_ffff, 1'b1, 32'h0, 32'h0, 1'b0}},
        '{MODE_SRLV,     32'h8000_0000, 32'h0000_0020, 1'b1,
          '{32'h8000_0000, 1'b1, 32'h0, 32'h0, 1'b0}},
        '{MODE_SLLV,     32'h0000_0001, 32'h0000_001f, 1'b1,
          '{32'h8000_0000, 1'b1, 32'h0, 32'h0, 1'b0}},
        '{MODE_XORI,     32'hffff_0000, 32'hffff_ffff, 1'b1,
          '{32'hffff_ffff, 1'b1, 32'h0, 32'h0, 1'b0}},
        '{MODE_NOR,      32'h0000_0000, 32'h0000_0000, 1'b1,
          '{32'hffff_ffff, 1'b1, 32'h0, 32'h0, 1'b0}},
        '{MODE_AND,      32'hffff_ffff, 32'hffff_ffff, 1'b1,
          '{32'hffff_ffff, 1'b1, 32'h0, 32'h0, 1'b0}},
        '{MODE_SLT,      32'h7fff_ffff, 32'h8000_0000, 1'b1,
          '{32'h0000_0000, 1'b1, 32'h0, 32'h0, 1'b0}},
        '{MODE_SUBU,     32'h0000_0000, 32'h0000_0001, 1'b1,
          '{32'hffff_ffff, 1'b1, 32'h0, 32'h0, 1'b0}},
        '{MODE_MOVN,     32'h1234_5678, 32'h0000_0000, 1'b1,
          '{32'h0000_0000, 1'b0, 32'h0, 32'h0, 1'b0}},
        '{MODE_MOVN,     32'hffff_ffff, 32'h8000_0000, 1'b1,
          '{32'hffff_ffff, 1'b1, 32'h0, 32'h0, 1'b0}},
        '{MODE_MOVZ,     32'hcafe_f00d, 32'h0000_0000, 1'b1,
          '{32'hcafe_f00d, 1'b1, 32'h0, 32'h0, 1'b0}},
        '{MODE_MOVZ,     32'h0000_0001, 32'h0000_0001, 1'b1,
          '{32'h0000_0000, 1'b0, 32'h0, 32'h0, 1'b0}},
        '{MODE_ORI,      32'h0000_0000, 32'hffff_ffff, 1'b1,
          '{32'h0000_ffff, 1'b1, 32'h0, 32'h0, 1'b0}},
        '{MODE_MULTU,    32'hffff_ffff, 32'hffff_ffff, 1'b1,
          '{32'h0000_0000, 1'b0, 32'hffff_fffe, 32'h0000_0001, 1'b1}},
        '{MODE_MULT,     32'h8000_0000, 32'h7fff_ffff, 1'b0, '0},
        '{MODE_SRL,      32'hffff_ffff, 32'h0000_001f, 1'b1,
          '{32'h0000_0001, 1'b1, 32'h0, 32'h0, 1'b0}},
        '{MODE_SLL,      32'h8765_4321, 32'hffff_ffe4, 1'b0, '0},
        '{MODE_SRAV,     32'h7fff_ffff, 32'h0000_003e, 1'b1,
          '{32'h0000_0001, 1'b1, 32'h0, 32'h0, 1'b0}},
        '{MODE_UNDEF_HI, 32'hffff_ffff, 32'hffff_ffff, 1'b1, '0}
    };

    mips32_integer_alu uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic alu_result_t predict_alu(logic [4:0] mode, logic [31:0] opa,
                                                logic [31:0] opb);
        alu_result_t res;
        logic [31:0] simm;
        logic [31:0] zimm;
        logic [4:0]  shamt;
        logic [63:0] prod;
        res            = '0;
        res.dest_write = 1'b1;
        simm           = {{16{opb[15]}}, opb[15:0]};
        zimm           = {16'h0000, opb[15:0]};
        shamt          = opb[4:0];
        case (mode)
            MODE_LUI:             res.dest_value = {opb[15:0], 16'h0000};
            MODE_OR:              res.dest_value = opa | opb;
            MODE_ADDIU:           res.dest_value = opa + simm;
            MODE_ADDU:            res.dest_value = opa + opb;
            MODE_XOR:             res.dest_value = opa ^ opb;
            MODE_SLTIU:           res.dest_value = 32'(opa < simm);
            MODE_SLTU:            res.dest_value = 32'(opa < opb);
            MODE_SLTI:            res.dest_value = 32'($signed(opa) < $signed(simm));
            MODE_SRA, MODE_SRAV:  res.dest_value = $signed(opa) >>> shamt;
            MODE_ANDI:            res.dest_value = opa & zimm;
            MODE_SRLV, MODE_SRL:  res.dest_value = opa >> shamt;
            MODE_SLLV, MODE_SLL:  res.dest_value = opa << shamt;
            MODE_XORI:            res.dest_value = opa ^ zimm;
            MODE_NOR:             res.dest_value = ~(opa | opb);
            MODE_AND:             res.dest_value = opa & opb;
            MODE_SLT:             res.dest_value = 32'($signed(opa) < $signed(opb));
            MODE_SUBU:            res.dest_value = opa - opb;
            MODE_MOVN:
            begin
                if (opb != 32'h0)
                    res.dest_value = opa;
                else
                    res.dest_write = 1'b0;
            end
            MODE_MOVZ:
            begin
                if (opb == 32'h0)
                    res.dest_value = opa;
                else
                    res.dest_write = 1'b0;
            end
            MODE_ORI:             res.dest_value = opa | zimm;
            MODE_MULTU, MODE_MULT:
            begin
                // Sign-extend for mult; the low 64 bits of the product are exact.
                if (mode == MODE_MULT)
                    prod = {{32{opa[31]}}, opa} * {{32{opb[31]}}, opb};
                else
                    prod = {32'h0, opa} * {32'h0, opb};
                res.hi_value   = prod[63:32];
                res.lo_value   = prod[31:0];
                res.hilo_write = 1'b1;
                res.dest_write = 1'b0;
            end
            default:              res.dest_write = 1'b0;
        endcase
        return res;
    endfunction

    // Stretches of back-to-back traffic between randomly idled ones.
    function automatic int unsigned draw_gap(int unsigned n);
        if ((n % 100) >= 70 && (n % 100) < 85)
            return 0;
        if ($urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 13);
    endfunction

    function automatic logic [31:0] draw_operand();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            2:       return 32'h8000_0000;
            3:       return 32'h7fff_ffff;
            4:       return $urandom_range(0, 40);
            default: return $urandom();
        endcase
    endfunction

    task automatic report_mismatch(int unsigned idx, string field, logic [31:0] got,
                                   logic [31:0] want);
        $display("ERROR: result %0d %s: got %h, expected %h", idx, field, got, want);
        err_count++;
    endtask

    task automatic send_item(logic [4:0] mode, logic [31:0] opa, logic [31:0] opb,
                             bit typed, alu_result_t want);
        int unsigned gap;
        gap = draw_gap(sent_count);
        if (gap != 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {opb, opa};
        s_tuser  = {3'b000, mode};
        do @(posedge clk); while (!s_tready);
        results_q.push_back(typed ? want : predict_alu(mode, opa, opb));
        sent_count++;
        @(negedge clk);
    endtask

    initial
    begin
        logic [4:0]  mode;
        logic [31:0] opa;
        logic [31:0] opb;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        m_tready   = 1'b0;
        sent_count = 0;
        err_count  = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].mode, dir_rows[i].opa, dir_rows[i].opb,
                      dir_rows[i].typed, dir_rows[i].want);

        for (int n = 0; n < NumRandom; n++)
        begin
            if ($urandom_range(0, 19) == 0)
                mode = 5'($urandom_range(MODE_UNDEF_LO, MODE_UNDEF_HI));
            else
                mode = 5'($urandom_range(0, MODE_SRAV));
            opa = draw_operand();
            opb = draw_operand();
            // Give the conditional moves a fair share of both outcomes.
            if ((mode == MODE_MOVN || mode == MODE_MOVZ) && $urandom_range(0, 1) == 0)
                opb = 32'h0;
            send_item(mode, opa, opb, 1'b0, '0);
        end
        s_tvalid = 1'b0;

        while (results_q.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : result_sink
        int unsigned stall;
        int unsigned taken;
        alu_result_t got;
        alu_result_t want;
        taken = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            // Hold off once for long enough to back up the input side.
            if (taken == HoldAt)
                stall = HoldCycles;
            else
                stall = draw_gap(taken);
            if (stall != 0)
            begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            do @(posedge clk); while (!m_tvalid);
            got.dest_value = m_tdata[31:0];
            got.hi_value   = m_tdata[63:32];
            got.lo_value   = m_tdata[95:64];
            got.dest_write = m_tuser[0];
            got.hilo_write = m_tuser[1];
            if (results_q.size() == 0)
                report_mismatch(taken, "unexpected item", got.dest_value, 32'h0);
            else
            begin
                want = results_q.pop_front();
                if (got.dest_value !== want.dest_value)
                    report_mismatch(taken, "dest_value", got.dest_value, want.dest_value);
                if (got.dest_write !== want.dest_write)
                    report_mismatch(taken, "dest_write", 32'(got.dest_write),
                                    32'(want.dest_write));
                if (got.hi_value !== want.hi_value)
                    report_mismatch(taken, "hi_value", got.hi_value, want.hi_value);
                if (got.lo_value !== want.lo_value)
                    report_mismatch(taken, "lo_value", got.lo_value, want.lo_value);
                if (got.hilo_write !== want.hilo_write)
                    report_mismatch(taken, "hilo_write", 32'(got.hilo_write),
                                    32'(want.hilo_write));
            end
            taken++;
        end
    end

    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/mia_pkg.sv
src/mia_exec.sv
src/mips32_integer_alu.sv
test/tb.sv
